// File: rtl/swr_pkg.sv
// Shared widths, status codes and register indexes for the sample-without-replacement unit.
package swr_pkg;

    // Field widths fixed by the interface.
    localparam int WORD_W     = 31;
    localparam int VALUE_W    = 32;
    localparam int DONE_W     = 13;
    localparam int STATUS_W   = 3;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_COUNT_WANTED = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_MIN    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_MAX    = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DRAWN     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_RESTARTED = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_PARAM = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_TOO_FEW   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_TOO_WIDE  = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_FINISHED  = 3'd5;

    // Slot table defaults and the width of the restart epoch kept with each entry.
    localparam int DEFAULT_TABLE_DEPTH = 4096;
    localparam int EPOCH_W             = 4;

endpackage

// File: rtl/swr_modulo.sv
// Bit-serial remainder unit: reduces a random word modulo a divisor, one bit per cycle.
module swr_modulo #(
    parameter int DIVISOR_W = $clog2(swr_pkg::DEFAULT_TABLE_DEPTH + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic [swr_pkg::WORD_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]      divisor,
    output logic                      done,
    output logic [DIVISOR_W-1:0]      remainder
);
    import swr_pkg::*;

    localparam int STEP_W = $clog2(WORD_W + 1);

    logic [WORD_W-1:0]    digits_reg, digits_next;
    logic [DIVISOR_W-1:0] divisor_reg, divisor_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 done_reg, done_next;
    logic [DIVISOR_W:0]   trial;

    // One restoring step: bring in the next dividend bit and subtract the divisor if it fits.
    always_comb
    begin
        trial        = {rem_reg, digits_reg[WORD_W-1]};
        digits_next  = digits_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        done_next    = 1'b0;
        if (load)
        begin
            digits_next  = dividend;
            divisor_next = divisor;
            rem_next     = '0;
            step_next    = STEP_W'(WORD_W);
        end
        else if (step_reg != '0)
        begin
            digits_next = {digits_reg[WORD_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next = DIVISOR_W'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
            end
            step_next = step_reg - 1'b1;
            done_next = (step_reg == STEP_W'(1));
        end
    end

    // Data path registers need no reset.
    always_ff @(posedge clk)
    begin
        digits_reg  <= digits_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/sample_without_replacement_unit.sv
// Top level of the sample-without-replacement unit: partial Fisher-Yates shuffle over a slot table.
//
//  Channel   Ports                                   Transfer taken when
//  -------   -------------------------------------   ------------------------------------
//  config    psel penable pwrite paddr pwdata         psel & penable & pwrite & pready
//            prdata pready
//  command   start restart random_word busy           start high while busy is low
//  result    done drawn_value status last             done high (one cycle, never held off)
//
// A draw runs through a check state, the bit-serial remainder unit (one bit of the random word
// per cycle, then a completion pulse), two table reads and one write on the slot memory, then
// the result. Restart, error and finished commands give their result from the check state
// without a draw.
// After reset, and on the restart that wraps the epoch counter (every fifteenth restart with a
// 4-bit epoch), a clearing pass over every slot-table entry runs with busy high; configuration
// transfers are still taken. The receiver cannot stall: each result is shown for one cycle.
module sample_without_replacement_unit #(
    parameter int TABLE_DEPTH = swr_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [swr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [swr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [swr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    // Command
    input  logic                               start,
    output logic                               busy,
    input  logic                               restart,
    input  logic [swr_pkg::WORD_W-1:0]         random_word,
    // Result
    output logic                               done,
    output logic signed [swr_pkg::VALUE_W-1:0] drawn_value,
    output logic [swr_pkg::STATUS_W-1:0]       status,
    output logic                               last
);
    import swr_pkg::*;

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int REM_W   = (CNT_W > DONE_W) ? CNT_W : DONE_W;
    localparam int ENTRY_W = EPOCH_W + IDX_W;
    localparam int DIFF_W  = VALUE_W + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_RD_IDX,
        ST_RD_TAIL,
        ST_WRITE
    } state_t;

    // Configuration registers
    logic [DONE_W-1:0]  count_wanted_reg;
    logic [VALUE_W-1:0] range_min_reg;
    logic [VALUE_W-1:0] range_max_reg;
    logic               cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;

    // Control state
    state_t             state_reg, state_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [DONE_W-1:0]  draws_done_reg, draws_done_next;
    logic [IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic               strobe_reg, strobe_next;

    // Working registers for one command
    logic               restart_reg, restart_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [DIFF_W-1:0]  diff_reg, diff_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [IDX_W-1:0]   chosen_reg, chosen_next;
    logic [VALUE_W-1:0] drawn_reg, drawn_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic               last_reg, last_next;

    // Slot memory: each entry holds the epoch it was written in and an offset
    logic [ENTRY_W-1:0] slot_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] mem_rdata_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [IDX_W-1:0]   mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               entry_live;
    logic [IDX_W-1:0]   entry_addr;
    logic [IDX_W-1:0]   entry_offset;

    // Parameter checks and draw set-up
    logic               accept;
    logic               bad_param;
    logic               too_few;
    logic               too_wide;
    logic               finished;
    logic [DIFF_W-1:0]  count_less_one;
    logic [REM_W-1:0]   tail_wide;
    logic [CNT_W-1:0]   remaining;
    logic               div_load;
    logic               div_done;
    logic [CNT_W-1:0]   div_rem;
    logic [DONE_W-1:0]  draws_inc;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign pready = 1'b1;

    // Configuration writes and reads
    assign cfg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_wanted_reg <= '0;
            range_min_reg    <= '0;
            range_max_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_COUNT_WANTED: count_wanted_reg <= pwdata[DONE_W-1:0];
                REG_RANGE_MIN:    range_min_reg    <= pwdata;
                REG_RANGE_MAX:    range_max_reg    <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_COUNT_WANTED: prdata = {{(APB_DATA_W-DONE_W){1'b0}}, count_wanted_reg};
            REG_RANGE_MIN:    prdata = range_min_reg;
            REG_RANGE_MAX:    prdata = range_max_reg;
            default:          prdata = '0;
        endcase
    end

    // Serial remainder unit
    swr_modulo #(
        .DIVISOR_W (CNT_W)
    ) u_modulo (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (div_load),
        .dividend  (word_reg),
        .divisor   (remaining),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Slot memory port: one write, one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= slot_mem[mem_raddr];
    end

    // An entry from an earlier epoch reads as its own index.
    assign entry_live   = (mem_rdata_reg[ENTRY_W-1:IDX_W] == epoch_reg);
    assign entry_offset = entry_live ? mem_rdata_reg[IDX_W-1:0] : entry_addr;

    // Checks on the wanted count, the latched range difference and the draws so far.
    assign count_less_one = DIFF_W'(count_wanted_reg) - DIFF_W'(1);
    assign bad_param = (count_wanted_reg == '0) || diff_reg[DIFF_W-1] || (diff_reg == '0);
    assign too_few   = (count_less_one > diff_reg);
    assign too_wide  = (diff_reg >= DIFF_W'(TABLE_DEPTH));
    assign finished  = (draws_done_reg >= count_wanted_reg);
    assign tail_wide = diff_reg[REM_W-1:0] - REM_W'(draws_done_reg);
    assign remaining = CNT_W'(tail_wide + REM_W'(1));
    assign draws_inc = draws_done_reg + 1'b1;

    // Next-state and data path control.
    always_comb
    begin
        state_next      = state_reg;
        epoch_next      = epoch_reg;
        draws_done_next = draws_done_reg;
        clr_cnt_next    = clr_cnt_reg;
        strobe_next     = 1'b0;
        restart_next    = restart_reg;
        word_next       = word_reg;
        diff_next       = diff_reg;
        idx_next        = idx_reg;
        tail_next       = tail_reg;
        chosen_next     = chosen_reg;
        drawn_next      = drawn_reg;
        status_next     = status_reg;
        last_next       = last_reg;
        div_load        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = {epoch_reg, entry_offset};
        mem_raddr       = idx_reg;
        entry_addr      = idx_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    restart_next = restart;
                    word_next    = random_word;
                    diff_next    = {range_max_reg[VALUE_W-1], range_max_reg}
                                 - {range_min_reg[VALUE_W-1], range_min_reg};
                    state_next   = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                drawn_next = '0;
                last_next  = 1'b0;
                state_next = ST_IDLE;
                priority if (restart_reg)
                begin
                    strobe_next     = 1'b1;
                    status_next     = STATUS_RESTARTED;
                    draws_done_next = '0;
                    if (epoch_reg == {EPOCH_W{1'b1}})
                    begin
                        epoch_next   = EPOCH_W'(1);
                        clr_cnt_next = '0;
                        state_next   = ST_CLEAR;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + 1'b1;
                    end
                end
                else if (bad_param)
                begin
                    strobe_next = 1'b1;
                    status_next = STATUS_BAD_PARAM;
                end
                else if (too_few)
                begin
                    strobe_next = 1'b1;
                    status_next = STATUS_TOO_FEW;
                end
                else if (too_wide)
                begin
                    strobe_next = 1'b1;
                    status_next = STATUS_TOO_WIDE;
                end
                else if (finished)
                begin
                    strobe_next = 1'b1;
                    status_next = STATUS_FINISHED;
                end
                else
                begin
                    div_load   = 1'b1;
                    tail_next  = tail_wide[IDX_W-1:0];
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    idx_next   = div_rem[IDX_W-1:0];
                    state_next = ST_RD_IDX;
                end
            end

            ST_RD_IDX:
            begin
                state_next = ST_RD_TAIL;
            end

            ST_RD_TAIL:
            begin
                // Chosen slot's data is back; start the read of the last remaining slot.
                mem_raddr   = tail_reg;
                chosen_next = entry_offset;
                state_next  = ST_WRITE;
            end

            ST_WRITE:
            begin
                // Move the last remaining offset into the chosen slot and give the result.
                entry_addr      = tail_reg;
                mem_we          = 1'b1;
                mem_waddr       = idx_reg;
                mem_wdata       = {epoch_reg, entry_offset};
                draws_done_next = draws_inc;
                strobe_next     = 1'b1;
                status_next     = STATUS_DRAWN;
                drawn_next      = range_min_reg + VALUE_W'(chosen_reg);
                last_next       = (draws_inc == count_wanted_reg);
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered result outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            epoch_reg      <= EPOCH_W'(1);
            draws_done_reg <= '0;
            clr_cnt_reg    <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            epoch_reg      <= epoch_next;
            draws_done_reg <= draws_done_next;
            clr_cnt_reg    <= clr_cnt_next;
            strobe_reg     <= strobe_next;
        end
    end

    // Working and payload registers need no reset.
    always_ff @(posedge clk)
    begin
        restart_reg <= restart_next;
        word_reg    <= word_next;
        diff_reg    <= diff_next;
        idx_reg     <= idx_next;
        tail_reg    <= tail_next;
        chosen_reg  <= chosen_next;
        drawn_reg   <= drawn_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
    end

    assign done        = strobe_reg;
    assign drawn_value = drawn_reg;
    assign status      = status_reg;
    assign last        = last_reg;

endmodule
